>>> hdl/fisu_pkg.sv
// ----------------------------------------------------------------------------
// fisu_pkg
// shared types, command codes and command tables of the data stack
// ----------------------------------------------------------------------------
package fisu_pkg;

  localparam int unsigned ActWidth = 5;
  localparam int unsigned CfgWidth = 7;
  localparam int unsigned StWidth  = 2;
  localparam int unsigned WinCells = 4;

  typedef enum logic [ActWidth-1:0] {
    ACT_PUSH   = 5'd0,
    ACT_POP    = 5'd1,
    ACT_PEEK   = 5'd2,
    ACT_DUP    = 5'd3,
    ACT_DROP   = 5'd4,
    ACT_SWAP   = 5'd5,
    ACT_OVER   = 5'd6,
    ACT_ROT    = 5'd7,
    ACT_2DUP   = 5'd8,
    ACT_2DROP  = 5'd9,
    ACT_2OVER  = 5'd10,
    ACT_2SWAP  = 5'd11,
    ACT_ADD    = 5'd12,
    ACT_SUB    = 5'd13,
    ACT_MUL    = 5'd14,
    ACT_DIV    = 5'd15,
    ACT_GT     = 5'd16,
    ACT_AND    = 5'd17,
    ACT_OR     = 5'd18
  } act_e;

  typedef enum logic [StWidth-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_DIVZERO   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SH_HOLD,
    SH_WIN,
    SH_UP1,
    SH_UP2,
    SH_DN1,
    SH_DN2
  } shift_e;

  typedef enum logic {
    FS_IDLE,
    FS_CALC
  } fsm_e;

  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

  function automatic logic [2:0] need_cnt(input logic [ActWidth-1:0] a);
    logic [2:0] n;
    case (act_e'(a))
      ACT_PUSH:                      n = 3'd0;
      ACT_POP, ACT_PEEK, ACT_DUP,
      ACT_DROP:                      n = 3'd1;
      ACT_ROT:                       n = 3'd3;
      ACT_2OVER, ACT_2SWAP:          n = 3'd4;
      ACT_SWAP, ACT_OVER, ACT_2DUP, ACT_2DROP, ACT_ADD, ACT_SUB, ACT_MUL,
      ACT_DIV, ACT_GT, ACT_AND, ACT_OR: n = 3'd2;
      default:                       n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] grow_cnt(input logic [ActWidth-1:0] a);
    logic [1:0] n;
    case (act_e'(a))
      ACT_PUSH, ACT_DUP, ACT_OVER: n = 2'd1;
      ACT_2DUP, ACT_2OVER:         n = 2'd2;
      default:                     n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] shrink_cnt(input logic [ActWidth-1:0] a);
    logic [1:0] n;
    case (act_e'(a))
      ACT_POP, ACT_DROP, ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_GT, ACT_AND,
      ACT_OR:    n = 2'd1;
      ACT_2DROP: n = 2'd2;
      default:   n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

>>> hdl/fisu_cell.sv
// ----------------------------------------------------------------------------
// fisu_cell
// one stack entry, loads from its own value, a neighbor or the top window
// ----------------------------------------------------------------------------
module fisu_cell #(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic                  clk_i,
  input  fisu_pkg::shift_e      sel_i,
  input  logic [WORD_WIDTH-1:0] win_i,
  input  logic [WORD_WIDTH-1:0] up1_i,
  input  logic [WORD_WIDTH-1:0] up2_i,
  input  logic [WORD_WIDTH-1:0] dn1_i,
  input  logic [WORD_WIDTH-1:0] dn2_i,
  output logic [WORD_WIDTH-1:0] word_o
);
  import fisu_pkg::*;

  logic [WORD_WIDTH-1:0] word_d, word_q;

  always_comb begin
    case (sel_i)
      SH_WIN:  word_d = win_i;
      SH_UP1:  word_d = up1_i;
      SH_UP2:  word_d = up2_i;
      SH_DN1:  word_d = dn1_i;
      SH_DN2:  word_d = dn2_i;
      default: word_d = word_q;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

>>> hdl/fisu_muldiv.sv
// ----------------------------------------------------------------------------
// fisu_muldiv
// radix-2 iterative multiplier and signed divider, one bit per cycle
// ----------------------------------------------------------------------------
module fisu_muldiv #(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fisu_pkg::md_req_t     req_i,
  input  logic [WORD_WIDTH-1:0] a_i,
  input  logic [WORD_WIDTH-1:0] b_i,
  output logic                  done_o,
  output logic [WORD_WIDTH-1:0] result_o
);
  import fisu_pkg::*;

  localparam int unsigned CntW = $clog2(WORD_WIDTH + 1);

  logic            busy_d, busy_q, done_d, done_q;
  logic [CntW-1:0] cnt_d, cnt_q;
  logic            div_d, div_q, neg_d, neg_q;
  logic [WORD_WIDTH-1:0] x_d, x_q, y_d, y_q, r_d, r_q;
  logic [WORD_WIDTH:0]   rem_sh, diff;
  logic [WORD_WIDTH-1:0] abs_a, abs_b;

  assign abs_a  = a_i[WORD_WIDTH-1] ? (~a_i + 1'b1) : a_i;
  assign abs_b  = b_i[WORD_WIDTH-1] ? (~b_i + 1'b1) : b_i;
  assign rem_sh = {r_q, x_q[WORD_WIDTH-1]};
  assign diff   = rem_sh - {1'b0, y_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    neg_d  = neg_q;
    x_d    = x_q;
    y_d    = y_q;
    r_d    = r_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(WORD_WIDTH);
      div_d  = req_i.is_div;
      neg_d  = a_i[WORD_WIDTH-1] ^ b_i[WORD_WIDTH-1];
      x_d    = req_i.is_div ? abs_a : a_i;
      y_d    = req_i.is_div ? abs_b : b_i;
      r_d    = '0;
    end else if (busy_q) begin
      if (div_q) begin
        // restoring step
        if (!diff[WORD_WIDTH]) begin
          r_d = diff[WORD_WIDTH-1:0];
          x_d = {x_q[WORD_WIDTH-2:0], 1'b1};
        end else begin
          r_d = rem_sh[WORD_WIDTH-1:0];
          x_d = {x_q[WORD_WIDTH-2:0], 1'b0};
        end
      end else begin
        r_d = r_q + (y_q[0] ? x_q : '0);
        x_d = {x_q[WORD_WIDTH-2:0], 1'b0};
        y_d = {1'b0, y_q[WORD_WIDTH-1:1]};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    neg_q <= neg_d;
    x_q   <= x_d;
    y_q   <= y_d;
    r_q   <= r_d;
  end

  assign done_o   = done_q;
  assign result_o = div_q ? (neg_q ? (~x_q + 1'b1) : x_q) : r_q;

endmodule

>>> hdl/forth_integer_stack_unit_top.sv
// ----------------------------------------------------------------------------
// forth_integer_stack_unit_top
// bounded forth data stack built as a shifting row of word cells
// ----------------------------------------------------------------------------
// One command item is taken at a time. Every command except mul and div
// is registered as a result item when it is accepted, and the next item is
// accepted at the same edge that takes the result, so with the result taken at
// once the block accepts an item every cycle. Mul and div run in a shared
// shift-add / restoring divide unit that handles one bit a cycle; the input
// side stays stalled until the result item is taken, and the next item is
// accepted at that same edge. A stalled result holds off the next item. A
// failed command (too few entries, no room, divide by zero) leaves the stack
// untouched. The top of the stack lives in cell 0; on each successful
// command the row shifts by the stack growth and the top four cells load the
// rearranged window.
module forth_integer_stack_unit_top #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned WORD_WIDTH  = 32,
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // command item
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [4:0]             action_i,
  input  logic signed [WORD_WIDTH-1:0] push_value_i,
  // result item
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             status_o,
  output logic signed [WORD_WIDTH-1:0] result_value_o,
  output logic [CW-1:0]          depth_o,
  // stack limit register
  input  logic                   cfg_we_i,
  input  logic [6:0]             cfg_data_i
);
  import fisu_pkg::*;

  // wide enough for count + growth and for the limit register
  localparam int unsigned LW = ((CW > CfgWidth) ? CW : CfgWidth) + 1;

  // control registers
  fsm_e                  fsm_d, fsm_q;
  logic [CW-1:0]         cnt_d, cnt_q;
  logic [CfgWidth-1:0]   lim_q;
  logic                  ovld_d, ovld_q;
  // payload registers
  logic [ActWidth-1:0]   act_q;
  logic [StWidth-1:0]    ost_d, ost_q;
  logic [WORD_WIDTH-1:0] oval_d, oval_q;
  logic [CW-1:0]         odep_d, odep_q;

  // cell row, padded by two words on each side
  logic [WORD_WIDTH-1:0] cell_q [STACK_DEPTH];
  logic [WORD_WIDTH-1:0] ext    [STACK_DEPTH+4];
  shift_e                sel    [STACK_DEPTH];
  logic [WORD_WIDTH-1:0] win    [WinCells];
  logic [WORD_WIDTH-1:0] o0, o1, o2, o3, o4, o5;

  // command decode
  logic                  accept, out_free, upd;
  logic [ActWidth-1:0]   act;
  logic [2:0]            need;
  logic [1:0]            grow, shrink;
  logic [LW-1:0]         c_ext, lim_ext;
  logic                  under, over, divz, is_md;
  logic [WORD_WIDTH-1:0] bin, alu;
  logic [CW-1:0]         cnt_new;
  md_req_t               md_req;
  logic                  md_done;
  logic [WORD_WIDTH-1:0] md_res;

  always_comb begin
    for (int k = 0; k < STACK_DEPTH + 4; k++) ext[k] = '0;
    for (int k = 0; k < STACK_DEPTH; k++) ext[k+2] = cell_q[k];
  end

  assign o0 = ext[2];
  assign o1 = ext[3];
  assign o2 = ext[4];
  assign o3 = ext[5];
  assign o4 = ext[6];
  assign o5 = ext[7];

  // output register empties or is taken this cycle
  assign out_free = !ovld_q || !out_stall_i;
  assign in_stall_o = (fsm_q != FS_IDLE) || !out_free;
  assign accept = in_valid_i && !in_stall_o;

  assign act    = (fsm_q == FS_CALC) ? act_q : action_i;
  assign need   = need_cnt(act);
  assign grow   = grow_cnt(act);
  assign shrink = shrink_cnt(act);
  assign c_ext  = LW'(cnt_q);
  assign lim_ext = (LW'(lim_q) > LW'(STACK_DEPTH)) ? LW'(STACK_DEPTH) : LW'(lim_q);
  assign under  = c_ext < LW'(need);
  assign over   = (grow != 2'd0) && ((c_ext + LW'(grow)) > lim_ext);
  assign divz   = (act == ACT_DIV) && (o0 == '0);
  assign is_md  = (act == ACT_MUL) || (act == ACT_DIV);
  assign cnt_new = cnt_q + CW'(grow) - CW'(shrink);

  // combinational binary ops on next (o1) and top (o0)
  always_comb begin
    case (act_e'(act))
      ACT_ADD: alu = o1 + o0;
      ACT_SUB: alu = o1 - o0;
      ACT_GT:  alu = ($signed(o1) > $signed(o0)) ? '1 : '0;
      ACT_AND: alu = ((o1 != '0) && (o0 != '0)) ? '1 : '0;
      default: alu = ((o1 != '0) || (o0 != '0)) ? '1 : '0;
    endcase
  end
  assign bin = (fsm_q == FS_CALC) ? md_res : alu;

  // rearranged top window, cell 0 is the top
  always_comb begin
    win[0] = o0; win[1] = o1; win[2] = o2; win[3] = o3;
    case (act_e'(act))
      ACT_PUSH: begin
        win[0] = push_value_i; win[1] = o0; win[2] = o1; win[3] = o2;
      end
      ACT_POP, ACT_DROP: begin
        win[0] = o1; win[1] = o2; win[2] = o3; win[3] = o4;
      end
      ACT_DUP: begin
        win[0] = o0; win[1] = o0; win[2] = o1; win[3] = o2;
      end
      ACT_SWAP: begin
        win[0] = o1; win[1] = o0;
      end
      ACT_OVER: begin
        win[0] = o1; win[1] = o0; win[2] = o1; win[3] = o2;
      end
      ACT_ROT: begin
        win[0] = o2; win[1] = o0; win[2] = o1;
      end
      ACT_2DUP: begin
        win[0] = o0; win[1] = o1; win[2] = o0; win[3] = o1;
      end
      ACT_2DROP: begin
        win[0] = o2; win[1] = o3; win[2] = o4; win[3] = o5;
      end
      ACT_2OVER, ACT_2SWAP: begin
        win[0] = o2; win[1] = o3; win[2] = o0; win[3] = o1;
      end
      ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_GT, ACT_AND, ACT_OR: begin
        win[0] = bin; win[1] = o2; win[2] = o3; win[3] = o4;
      end
      default: ;
    endcase
  end

  // sequencer: next state, cell update, result item
  always_comb begin
    fsm_d  = fsm_q;
    cnt_d  = cnt_q;
    upd    = 1'b0;
    md_req = '0;
    ovld_d = ovld_q && out_stall_i;
    ost_d  = ost_q;
    oval_d = oval_q;
    odep_d = odep_q;
    case (fsm_q)
      FS_IDLE: begin
        if (accept) begin
          ovld_d = 1'b1;
          odep_d = cnt_q;
          oval_d = (cnt_q != '0) ? o0 : '0;
          if (action_i >= ActWidth'(ACT_OR) + 1'b1) begin
            ost_d = ST_OK;
          end else if (under) begin
            ost_d = ST_UNDERFLOW;
          end else if (over) begin
            ost_d = ST_OVERFLOW;
          end else if (divz) begin
            ost_d = ST_DIVZERO;
          end else if (is_md) begin
            // result comes when the iterative unit finishes
            ovld_d = 1'b0;
            md_req.start  = 1'b1;
            md_req.is_div = (act == ACT_DIV);
            fsm_d = FS_CALC;
          end else begin
            upd    = 1'b1;
            ost_d  = ST_OK;
            cnt_d  = cnt_new;
            odep_d = cnt_new;
            if (act == ACT_POP) oval_d = o0;
            else oval_d = (cnt_new != '0) ? win[0] : '0;
          end
        end
      end
      FS_CALC: begin
        if (md_done && out_free) begin
          upd    = 1'b1;
          cnt_d  = cnt_new;
          ovld_d = 1'b1;
          ost_d  = ST_OK;
          odep_d = cnt_new;
          oval_d = win[0];
          fsm_d  = FS_IDLE;
        end
      end
      default: fsm_d = FS_IDLE;
    endcase
  end

  // per-cell select: top four take the window, the rest shift by growth
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_sel
    if (i < WinCells) begin : g_win
      assign sel[i] = upd ? SH_WIN : SH_HOLD;
    end else begin : g_row
      always_comb begin
        sel[i] = SH_HOLD;
        if (upd) begin
          if (grow == 2'd1) sel[i] = SH_UP1;
          else if (grow == 2'd2) sel[i] = SH_UP2;
          else if (shrink == 2'd1) sel[i] = SH_DN1;
          else if (shrink == 2'd2) sel[i] = SH_DN2;
        end
      end
    end
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    fisu_cell #(
      .WORD_WIDTH(WORD_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .sel_i  (sel[i]),
      .win_i  ((i < WinCells) ? win[i % WinCells] : ext[i+2]),
      .up1_i  (ext[i+1]),
      .up2_i  (ext[i]),
      .dn1_i  (ext[i+3]),
      .dn2_i  (ext[i+4]),
      .word_o (cell_q[i])
    );
  end

  fisu_muldiv #(
    .WORD_WIDTH(WORD_WIDTH)
  ) u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (md_req),
    .a_i      (o1),
    .b_i      (o0),
    .done_o   (md_done),
    .result_o (md_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q  <= FS_IDLE;
      cnt_q  <= '0;
      lim_q  <= CfgWidth'(64);
      ovld_q <= 1'b0;
    end else begin
      fsm_q  <= fsm_d;
      cnt_q  <= cnt_d;
      ovld_q <= ovld_d;
      if (cfg_we_i) lim_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) act_q <= action_i;
    ost_q  <= ost_d;
    oval_q <= oval_d;
    odep_q <= odep_d;
  end

  assign out_valid_o    = ovld_q;
  assign status_o       = ost_q;
  assign result_value_o = oval_q;
  assign depth_o        = odep_q;

endmodule

>>> hdl/fisu_checker.sv
// ----------------------------------------------------------------------------
// fisu_checker
// port-level checks of the data stack, bound to the top level
// ----------------------------------------------------------------------------
module fisu_checker #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned WORD_WIDTH  = 32,
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1)
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [1:0]            status_o,
  input logic [WORD_WIDTH-1:0] result_value_o,
  input logic [CW-1:0]         depth_o
);
  import fisu_pkg::*;

  // an accepted item holds the input side or shows up as a result
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o || in_stall_o)
    else $error("accepted item neither pending nor delivered");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> depth_o <= CW'(STACK_DEPTH))
    else $error("depth beyond stack size");

  // empty stack after a failed command reads as zero
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) && (depth_o == '0) |-> result_value_o == '0)
    else $error("failed command on empty stack shows nonzero value");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_value_o)
      && $stable(status_o) && $stable(depth_o))
    else $error("stalled result item changed");

endmodule

bind forth_integer_stack_unit_top fisu_checker #(
  .STACK_DEPTH(STACK_DEPTH),
  .WORD_WIDTH (WORD_WIDTH)
) u_fisu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .result_value_o (result_value_o),
  .depth_o        (depth_o)
);
